>>> src/euler_angles_to_basis_vectors_assert.svh
// Assertion macros for the Euler angle to basis vector block.
// No dependencies; included by the top level only.
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_ASSERT_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_ASSERT_SVH
`ifndef SYNTHESIS
`define EAB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define EAB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define EAB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define EAB_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> src/e2b_pkg.sv
// Shared constants for the Euler angle to basis vector block:
// default parameters, CORDIC gain and arctangent table. No dependencies.
package e2b_pkg;

    localparam int ANGLE_WIDTH_DEF    = 16;
    localparam int FRACTION_BITS_DEF  = 15;
    localparam int ROTATION_STEPS_DEF = 16;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] GAIN_Q31 = 32'h4DBA_76D4;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
    };

endpackage

>>> src/e2b_cordic.sv
// Pipelined rotation-mode CORDIC: one binary angle in, saturated sine and cosine out.
// Depends on e2b_pkg.
module e2b_cordic #(
    parameter int ANGLE_WIDTH    = e2b_pkg::ANGLE_WIDTH_DEF,
    parameter int FRACTION_BITS  = e2b_pkg::FRACTION_BITS_DEF,
    parameter int ROTATION_STEPS = e2b_pkg::ROTATION_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ANGLE_WIDTH-1:0]        i_angle,
    output logic                          o_valid,
    output logic signed [FRACTION_BITS:0] o_sin,
    output logic signed [FRACTION_BITS:0] o_cos
);
    import e2b_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int XW    = F + 3;
    localparam int NSTEP = (ROTATION_STEPS < ATAN_ENTRIES) ? ROTATION_STEPS : ATAN_ENTRIES;
    localparam logic [32:0] GAIN_RND =
        {1'b0, GAIN_Q31} + (33'd1 << (30 - F));
    localparam logic signed [XW-1:0] X_INIT = XW'(GAIN_RND >> (31 - F));
    localparam logic signed [XW-1:0] LIM    = XW'((1 << F) - 1);

    logic [31:0] a32;
    logic [31:0] a32_rnd;
    logic [1:0]  quad;

    logic                 r_vld [0:NSTEP];
    logic signed [XW-1:0] r_x   [0:NSTEP];
    logic signed [XW-1:0] r_y   [0:NSTEP];
    logic signed [31:0]   r_z   [0:NSTEP];
    logic [1:0]           r_q   [0:NSTEP];

    logic signed [XW-1:0] n_c;
    logic signed [XW-1:0] n_s;
    logic                 r_out_vld;
    logic signed [F:0]    r_sin;
    logic signed [F:0]    r_cos;

    assign a32     = {i_angle, {(32 - ANGLE_WIDTH){1'b0}}};
    assign a32_rnd = a32 + 32'h2000_0000;
    assign quad    = a32_rnd[31:30];

    // fold to nearest quadrant, keep residual
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_x[0] <= X_INIT;
        r_y[0] <= '0;
        r_z[0] <= signed'(a32 - {quad, 30'd0});
        r_q[0] <= quad;
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - signed'(ATAN_TURNS[i]);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + signed'(ATAN_TURNS[i]);
            end
            r_q[i+1] <= r_q[i];
        end
    end

    always_comb begin
        case (r_q[NSTEP])
            2'd0: begin n_c = r_x[NSTEP];  n_s = r_y[NSTEP];  end
            2'd1: begin n_c = -r_y[NSTEP]; n_s = r_x[NSTEP];  end
            2'd2: begin n_c = -r_x[NSTEP]; n_s = -r_y[NSTEP]; end
            default: begin n_c = r_y[NSTEP]; n_s = -r_x[NSTEP]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[NSTEP];
        end
        if (n_c > LIM) begin
            r_cos <= LIM[F:0];
        end else if (n_c < -LIM) begin
            r_cos <= -LIM[F:0];
        end else begin
            r_cos <= n_c[F:0];
        end
        if (n_s > LIM) begin
            r_sin <= LIM[F:0];
        end else if (n_s < -LIM) begin
            r_sin <= -LIM[F:0];
        end else begin
            r_sin <= n_s[F:0];
        end
    end

    assign o_valid = r_out_vld;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

>>> src/e2b_mix.sv
// Three-stage product and sum pipeline forming the nine basis vector components.
// Depends on e2b_pkg.
module e2b_mix #(
    parameter int FRACTION_BITS = e2b_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [FRACTION_BITS:0] i_sp,
    input  logic signed [FRACTION_BITS:0] i_cp,
    input  logic signed [FRACTION_BITS:0] i_sy,
    input  logic signed [FRACTION_BITS:0] i_cy,
    input  logic signed [FRACTION_BITS:0] i_sr,
    input  logic signed [FRACTION_BITS:0] i_cr,
    output logic                          o_valid,
    output logic signed [FRACTION_BITS:0] o_forward_x,
    output logic signed [FRACTION_BITS:0] o_forward_y,
    output logic signed [FRACTION_BITS:0] o_forward_z,
    output logic signed [FRACTION_BITS:0] o_right_x,
    output logic signed [FRACTION_BITS:0] o_right_y,
    output logic signed [FRACTION_BITS:0] o_right_z,
    output logic signed [FRACTION_BITS:0] o_up_x,
    output logic signed [FRACTION_BITS:0] o_up_y,
    output logic signed [FRACTION_BITS:0] o_up_z
);
    import e2b_pkg::*;

    localparam int F = FRACTION_BITS;
    localparam logic signed [2*F+1:0] RND = (2*F+2)'(1) <<< (F - 1);
    localparam logic signed [F+1:0]   LIM = (F+2)'((1 << F) - 1);

    function automatic logic signed [F:0] fmul(input logic signed [F:0] a,
                                               input logic signed [F:0] b);
        logic signed [2*F+1:0] p;
        p = a * b + RND;
        return p[2*F:F];
    endfunction

    function automatic logic signed [F:0] sat(input logic signed [F+1:0] v);
        logic signed [F:0] res;
        if (v > LIM) begin
            res = LIM[F:0];
        end else if (v < -LIM) begin
            res = -LIM[F:0];
        end else begin
            res = v[F:0];
        end
        return res;
    endfunction

    // stage 1: two-factor products
    logic r1_vld;
    logic signed [F:0] r1_t, r1_u, r1_fx, r1_fy, r1_fz, r1_crsy, r1_crcy;
    logic signed [F:0] r1_rz, r1_srsy, r1_srcy, r1_uz, r1_sy, r1_cy;
    // stage 2: three-factor products
    logic r2_vld;
    logic signed [F:0] r2_ty, r2_tc, r2_uy, r2_uc, r2_fx, r2_fy, r2_fz;
    logic signed [F:0] r2_crsy, r2_crcy, r2_rz, r2_srsy, r2_srcy, r2_uz;
    // stage 3: sums and saturation
    logic r3_vld;
    logic signed [F:0] r3_fx, r3_fy, r3_fz, r3_rx, r3_ry, r3_rz;
    logic signed [F:0] r3_ux, r3_uy, r3_uz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end

        r1_t    <= fmul(i_sr, i_sp);
        r1_u    <= fmul(i_cr, i_sp);
        r1_fx   <= fmul(i_cp, i_cy);
        r1_fy   <= fmul(i_cp, i_sy);
        r1_fz   <= -i_sp;
        r1_crsy <= fmul(i_cr, i_sy);
        r1_crcy <= fmul(i_cr, i_cy);
        r1_rz   <= -fmul(i_sr, i_cp);
        r1_srsy <= fmul(i_sr, i_sy);
        r1_srcy <= fmul(i_sr, i_cy);
        r1_uz   <= fmul(i_cr, i_cp);
        r1_sy   <= i_sy;
        r1_cy   <= i_cy;

        r2_tc   <= fmul(r1_t, r1_cy);
        r2_ty   <= fmul(r1_t, r1_sy);
        r2_uc   <= fmul(r1_u, r1_cy);
        r2_uy   <= fmul(r1_u, r1_sy);
        r2_fx   <= r1_fx;
        r2_fy   <= r1_fy;
        r2_fz   <= r1_fz;
        r2_crsy <= r1_crsy;
        r2_crcy <= r1_crcy;
        r2_rz   <= r1_rz;
        r2_srsy <= r1_srsy;
        r2_srcy <= r1_srcy;
        r2_uz   <= r1_uz;

        r3_fx <= r2_fx;
        r3_fy <= r2_fy;
        r3_fz <= r2_fz;
        r3_rx <= sat((F+2)'(r2_crsy) - (F+2)'(r2_tc));
        r3_ry <= sat(-(F+2)'(r2_ty) - (F+2)'(r2_crcy));
        r3_rz <= r2_rz;
        r3_ux <= sat((F+2)'(r2_uc) + (F+2)'(r2_srsy));
        r3_uy <= sat((F+2)'(r2_uy) - (F+2)'(r2_srcy));
        r3_uz <= r2_uz;
    end

    assign o_valid     = r3_vld;
    assign o_forward_x = r3_fx;
    assign o_forward_y = r3_fy;
    assign o_forward_z = r3_fz;
    assign o_right_x   = r3_rx;
    assign o_right_y   = r3_ry;
    assign o_right_z   = r3_rz;
    assign o_up_x      = r3_ux;
    assign o_up_y      = r3_uy;
    assign o_up_z      = r3_uz;

endmodule

>>> src/euler_angles_to_basis_vectors.sv
// Euler angles to forward/right/up basis vectors, fully pipelined.
// Rotation steps are capped at the 24 arctangent table entries: min(ROTATION_STEPS,24).
// Throughput: one request per cycle; o_busy is always low and results cannot be stalled.
// Built from three parallel CORDIC pipelines, one stage per rotation step, then three mix stages.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// Depends on e2b_pkg, e2b_cordic, e2b_mix and euler_angles_to_basis_vectors_assert.svh.
`include "euler_angles_to_basis_vectors_assert.svh"
module euler_angles_to_basis_vectors #(
    parameter int ANGLE_WIDTH    = e2b_pkg::ANGLE_WIDTH_DEF,
    parameter int FRACTION_BITS  = e2b_pkg::FRACTION_BITS_DEF,
    parameter int ROTATION_STEPS = e2b_pkg::ROTATION_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [ANGLE_WIDTH-1:0]        i_pitch_angle,
    input  logic [ANGLE_WIDTH-1:0]        i_yaw_angle,
    input  logic [ANGLE_WIDTH-1:0]        i_roll_angle,
    output logic                          o_done,
    output logic signed [FRACTION_BITS:0] o_forward_x,
    output logic signed [FRACTION_BITS:0] o_forward_y,
    output logic signed [FRACTION_BITS:0] o_forward_z,
    output logic signed [FRACTION_BITS:0] o_right_x,
    output logic signed [FRACTION_BITS:0] o_right_y,
    output logic signed [FRACTION_BITS:0] o_right_z,
    output logic signed [FRACTION_BITS:0] o_up_x,
    output logic signed [FRACTION_BITS:0] o_up_y,
    output logic signed [FRACTION_BITS:0] o_up_z
);
    import e2b_pkg::*;

    localparam int F       = FRACTION_BITS;
    localparam int NSTEP   = (ROTATION_STEPS < ATAN_ENTRIES) ? ROTATION_STEPS : ATAN_ENTRIES;
    localparam int LATENCY = NSTEP + 5;
    localparam logic signed [F:0] MOST_NEG = {1'b1, {F{1'b0}}};

    logic              accept;
    logic              vld_p, vld_y, vld_r;
    logic signed [F:0] sp, cp, sy, cy, sr, cr;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    e2b_cordic #(
        .ANGLE_WIDTH(ANGLE_WIDTH), .FRACTION_BITS(F), .ROTATION_STEPS(ROTATION_STEPS)
    ) u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_angle(i_pitch_angle),
        .o_valid(vld_p), .o_sin(sp), .o_cos(cp)
    );

    e2b_cordic #(
        .ANGLE_WIDTH(ANGLE_WIDTH), .FRACTION_BITS(F), .ROTATION_STEPS(ROTATION_STEPS)
    ) u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_angle(i_yaw_angle),
        .o_valid(vld_y), .o_sin(sy), .o_cos(cy)
    );

    e2b_cordic #(
        .ANGLE_WIDTH(ANGLE_WIDTH), .FRACTION_BITS(F), .ROTATION_STEPS(ROTATION_STEPS)
    ) u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_angle(i_roll_angle),
        .o_valid(vld_r), .o_sin(sr), .o_cos(cr)
    );

    e2b_mix #(
        .FRACTION_BITS(F)
    ) u_mix (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(vld_p),
        .i_sp(sp), .i_cp(cp), .i_sy(sy), .i_cy(cy), .i_sr(sr), .i_cr(cr),
        .o_valid(o_done),
        .o_forward_x(o_forward_x), .o_forward_y(o_forward_y), .o_forward_z(o_forward_z),
        .o_right_x(o_right_x), .o_right_y(o_right_y), .o_right_z(o_right_z),
        .o_up_x(o_up_x), .o_up_y(o_up_y), .o_up_z(o_up_z)
    );

    `EAB_ASSERT_NEVER(a_lanes_aligned, i_clk, i_rst_n, (vld_p != vld_y) || (vld_p != vld_r))
    `EAB_ASSERT_IMPLY(a_done_latency, i_clk, i_rst_n, o_done, $past(accept, LATENCY))
    `EAB_ASSERT_IMPLY(a_no_most_neg, i_clk, i_rst_n, o_done,
        (o_right_x != MOST_NEG) && (o_right_y != MOST_NEG) &&
        (o_up_x != MOST_NEG) && (o_up_y != MOST_NEG))

endmodule
